// ===== design/fdcs_pkg.sv =====
// Shared types, constants and word-building function for the flip-dot column drive sequencer.
package fdcs_pkg;

	localparam int COLUMN_BITS_DEFAULT = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [15:0] SELECT_HOLD_US = 16'd100;
	localparam logic [2:0] MAX_PANEL = 3'd5;
	localparam logic [2:0] PANEL_CODE_SIX = 3'd6;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_POWER_OFF = 2'd1;
	localparam logic [1:0] STATUS_BAD_PANEL = 2'd2;

	typedef struct packed {
		logic [15:0] column_bits;
		logic [2:0]  panel_index;
		logic        first_of_panel;
		logic        last_of_panel;
		logic [15:0] clear_time_us;
		logic [15:0] on_time_us;
	} col_beat_t;

	typedef struct packed {
		logic [31:0] register_word;
		logic        select6_level;
		logic [15:0] hold_us;
		logic [1:0]  status;
		logic        last_word;
	} word_beat_t;

	// classified column command handed from front to back
	typedef struct packed {
		logic        is_err;
		logic [1:0]  status;
		logic [15:0] bits;
		logic [2:0]  code;
		logic        first;
		logic        last;
		logic [15:0] clr_us;
		logic [15:0] on_us;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  panel_code;
		logic        clock_level;
		logic        reset_level;
		logic        clear_level;
		logic [15:0] column_drive;
	} line_t;

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b000_0000_0001,
		ST_SEL0    = 11'b000_0000_0010,
		ST_SEL1    = 11'b000_0000_0100,
		ST_CLK1    = 11'b000_0000_1000,
		ST_CLR     = 11'b000_0001_0000,
		ST_CLR_END = 11'b000_0010_0000,
		ST_CLK2    = 11'b000_0100_0000,
		ST_DRV     = 11'b000_1000_0000,
		ST_DRV_END = 11'b001_0000_0000,
		ST_RST     = 11'b010_0000_0000,
		ST_ERR     = 11'b100_0000_0000
	} step_t;

	function automatic logic [31:0] make_word(input line_t ln);
		logic [7:0] sel;
		logic [7:0] b1;
		sel = (8'd1 << ln.panel_code) >> 1;
		b1 = {ln.clear_level, ~ln.reset_level, ~ln.clock_level, ~sel[4:0]};
		return {8'h00, b1, ln.column_drive};
	endfunction

endpackage

// ===== design/fdcs_front.sv =====
// Front end: supply enable register, column intake and classification into commands.
module fdcs_front import fdcs_pkg::*; #(
	parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      supply_en_we,
	input  logic      supply_en_wdata,
	input  logic      col_valid,
	output logic      col_stall,
	input  col_beat_t col_beat,
	input  logic      q_full,
	output logic      q_push,
	output cmd_t      q_data
);

	localparam logic [15:0] COL_MASK = 16'((32'd1 << COLUMN_BITS) - 32'd1);

	logic supply_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_en_q <= 1'b0;
		end else if (supply_en_we) begin
			supply_en_q <= supply_en_wdata;
		end
	end

	assign col_stall = q_full;
	assign q_push = col_valid && !q_full;

	always_comb begin
		q_data.is_err = 1'b0;
		q_data.status = STATUS_OK;
		if (!supply_en_q) begin
			q_data.is_err = 1'b1;
			q_data.status = STATUS_POWER_OFF;
		end else if (col_beat.panel_index > MAX_PANEL) begin
			q_data.is_err = 1'b1;
			q_data.status = STATUS_BAD_PANEL;
		end
		q_data.bits = col_beat.column_bits & COL_MASK;
		q_data.code = col_beat.panel_index + 3'd1;
		q_data.first = col_beat.first_of_panel;
		q_data.last = col_beat.last_of_panel;
		q_data.clr_us = col_beat.clear_time_us;
		q_data.on_us = col_beat.on_time_us;
	end

endmodule

// ===== design/fdcs_queue.sv =====
// Short command queue between front and back.
module fdcs_queue import fdcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t pop_data
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign full = (count_q == DEPTH_C);
	assign valid = (count_q != '0);
	assign do_pop = pop && valid;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/fdcs_back.sv =====
// Back end: steps through the drive words of one command and holds the output register.
module fdcs_back import fdcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  cmd_t       q_data,
	output logic       q_pop,
	output logic       word_valid,
	input  logic       word_stall,
	output word_beat_t word_beat
);

	step_t      step_q;
	step_t      step_nxt;
	step_t      step_start;
	cmd_t       cmd_q;
	line_t      line_q;
	line_t      line_nxt;
	word_beat_t beat_q;
	word_beat_t beat_nxt;
	logic       out_valid_q;
	logic       emit;
	logic       is_last;
	logic       idle;

	assign idle = (step_q == ST_IDLE);
	assign emit = !idle && (!out_valid_q || !word_stall);
	assign q_pop = q_valid && (idle || (emit && is_last));

	always_comb begin
		if (q_data.is_err) begin
			step_start = ST_ERR;
		end else if (q_data.first) begin
			step_start = ST_SEL0;
		end else begin
			step_start = ST_CLK1;
		end
	end

	always_comb begin
		line_nxt = line_q;
		step_nxt = ST_IDLE;
		beat_nxt.hold_us = 16'd0;
		beat_nxt.status = STATUS_OK;
		unique case (step_q)
			ST_SEL0: begin
				line_nxt.clock_level = 1'b0;
				line_nxt.reset_level = 1'b1;
				beat_nxt.hold_us = SELECT_HOLD_US;
				step_nxt = ST_SEL1;
			end
			ST_SEL1: begin
				line_nxt.panel_code = cmd_q.code;
				line_nxt.reset_level = 1'b0;
				beat_nxt.hold_us = SELECT_HOLD_US;
				step_nxt = ST_CLK1;
			end
			ST_CLK1: begin
				line_nxt.clock_level = 1'b1;
				step_nxt = ST_CLR;
			end
			ST_CLR: begin
				line_nxt.panel_code = 3'd0;
				line_nxt.clock_level = 1'b0;
				if (cmd_q.clr_us != 16'd0) begin
					line_nxt.clear_level = 1'b1;
				end
				beat_nxt.hold_us = cmd_q.clr_us;
				step_nxt = (cmd_q.clr_us != 16'd0) ? ST_CLR_END : ST_CLK2;
			end
			ST_CLR_END: begin
				line_nxt.clear_level = 1'b0;
				step_nxt = ST_CLK2;
			end
			ST_CLK2: begin
				line_nxt.clock_level = 1'b1;
				step_nxt = ST_DRV;
			end
			ST_DRV: begin
				line_nxt.clock_level = 1'b0;
				if (cmd_q.on_us != 16'd0) begin
					line_nxt.column_drive = cmd_q.bits;
				end
				beat_nxt.hold_us = cmd_q.on_us;
				if (cmd_q.on_us != 16'd0) begin
					step_nxt = ST_DRV_END;
				end else begin
					step_nxt = cmd_q.last ? ST_RST : ST_IDLE;
				end
			end
			ST_DRV_END: begin
				line_nxt.column_drive = 16'd0;
				step_nxt = cmd_q.last ? ST_RST : ST_IDLE;
			end
			ST_RST: begin
				line_nxt.reset_level = 1'b1;
			end
			ST_ERR: begin
				beat_nxt.status = cmd_q.status;
			end
			ST_IDLE: begin
			end
			default: begin
			end
		endcase
		is_last = (step_nxt == ST_IDLE);
		beat_nxt.last_word = is_last;
		if (step_q == ST_ERR) begin
			beat_nxt.register_word = 32'd0;
			beat_nxt.select6_level = 1'b0;
		end else begin
			beat_nxt.register_word = make_word(line_nxt);
			beat_nxt.select6_level = (line_nxt.panel_code != PANEL_CODE_SIX);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (emit) begin
			beat_q <= beat_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			line_q <= '{panel_code: 3'd0, clock_level: 1'b0, reset_level: 1'b1,
				clear_level: 1'b0, column_drive: 16'd0};
		end else begin
			if (q_pop) begin
				step_q <= step_start;
			end else if (emit) begin
				step_q <= step_nxt;
			end
			if (emit) begin
				line_q <= line_nxt;
				out_valid_q <= 1'b1;
			end else if (!word_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign word_valid = out_valid_q;
	assign word_beat = beat_q;

endmodule

// ===== design/flip_dot_column_drive_sequencer.sv =====
// Flip-dot column drive sequencer: top level joining front, queue and back.
//
// Columns arrive on the col channel (col_valid / col_stall / col_beat), one
// column per beat. Each column produces one to nine shift register words on
// the word channel (word_valid / word_stall / word_beat), one word per cycle
// while the receiver takes them; last_word marks the final word of a column.
// A refused column (supply off or panel above 5) yields a single error word.
// The supply enable is written through supply_en_we / supply_en_wdata; the user
// must do so only while idle: the block does not enforce it. A column beat taken
// when the block is empty goes into the queue, then the back end's command and
// step registers; its first word is then registered into the output beat.
// The back end's word sequencer gives one word per cycle while the receiver takes
// words, and moves straight on to the next queued column after the final word.
// A two-entry command queue decouples intake from sequencing; col_stall
// rises only when it is full. When the receiver stalls, the held word stays
// put, the sequencer waits, and the queue fills before intake stalls.
// Reset clears the supply enable, the queue and the line state (reset line high).
module flip_dot_column_drive_sequencer import fdcs_pkg::*; #(
	parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       supply_en_we,
	input  logic       supply_en_wdata,
	input  logic       col_valid,
	output logic       col_stall,
	input  col_beat_t  col_beat,
	output logic       word_valid,
	input  logic       word_stall,
	output word_beat_t word_beat
);

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_valid;
	cmd_t q_wdata;
	cmd_t q_rdata;

	fdcs_front #(
		.COLUMN_BITS(COLUMN_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.supply_en_we   (supply_en_we),
		.supply_en_wdata(supply_en_wdata),
		.col_valid      (col_valid),
		.col_stall      (col_stall),
		.col_beat       (col_beat),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_data         (q_wdata)
	);

	fdcs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.pop_data (q_rdata)
	);

	fdcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.word_valid(word_valid),
		.word_stall(word_stall),
		.word_beat (word_beat)
	);

endmodule
